FILE: src/u128div_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u128div_pkg;

	// Operand and quotient widths.
	localparam int HALF_W = 64;
	localparam int WORD_W = 2 * HALF_W;
	// Alignment shift count, 0 to WORD_W - 1.
	localparam int CNT_W = $clog2(WORD_W);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic shift_up;
		logic step;
		logic publish;
	} u128div_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic dbz;
		logic can_shift;
		logic cnt_zero;
	} u128div_sts_t;

endpackage

`default_nettype wire

FILE: src/u128div_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one beat carries a dividend and a divisor.
interface u128div_req_if;
	import u128div_pkg::*;
	logic              valid;
	logic              ready;
	logic [HALF_W-1:0] dividend_high;
	logic [HALF_W-1:0] dividend_low;
	logic [HALF_W-1:0] divisor_high;
	logic [HALF_W-1:0] divisor_low;

	modport source (
		output valid, dividend_high, dividend_low, divisor_high, divisor_low,
		input  ready
	);
	modport sink (
		input  valid, dividend_high, dividend_low, divisor_high, divisor_low,
		output ready
	);
endinterface

// Response channel: one beat carries the quotient and the zero-divisor flag.
interface u128div_rsp_if;
	import u128div_pkg::*;
	logic              valid;
	logic              ready;
	logic [HALF_W-1:0] quotient_high;
	logic [HALF_W-1:0] quotient_low;
	logic              divide_by_zero;

	modport source (
		output valid, quotient_high, quotient_low, divide_by_zero,
		input  ready
	);
	modport sink (
		input  valid, quotient_high, quotient_low, divide_by_zero,
		output ready
	);
endinterface

`default_nettype wire

FILE: src/uint128_restoring_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted beat is loaded, then the divisor is aligned by s left shifts (s from 0 to
// 127) and division steps give one quotient bit per cycle until the shift count is zero;
// a zero divisor skips to the result. The result is published once the output beat is free,
// and only then is a new beat taken; a single 128-bit subtractor serves compares and steps.
// Reset: arst_n clears state, result valid, shift count, zero-divisor flag; data hold.

module uint128_restoring_divider
	import u128div_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	u128div_req_if.sink   req,
	u128div_rsp_if.source rsp
);

	u128div_cmd_t cmd;
	u128div_sts_t sts;

	// Sequencer for alignment, division steps and result hand-off.
	u128div_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Shift-and-subtract datapath with the output register.
	u128div_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.dividend_high  (req.dividend_high),
		.dividend_low   (req.dividend_low),
		.divisor_high   (req.divisor_high),
		.divisor_low    (req.divisor_low),
		.quotient_high  (rsp.quotient_high),
		.quotient_low   (rsp.quotient_low),
		.divide_by_zero (rsp.divide_by_zero)
	);

endmodule

`default_nettype wire

FILE: src/u128div_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module u128div_dp
	import u128div_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire u128div_cmd_t      cmd,
	output u128div_sts_t           sts,
	input  wire logic [HALF_W-1:0] dividend_high,
	input  wire logic [HALF_W-1:0] dividend_low,
	input  wire logic [HALF_W-1:0] divisor_high,
	input  wire logic [HALF_W-1:0] divisor_low,
	output logic      [HALF_W-1:0] quotient_high,
	output logic      [HALF_W-1:0] quotient_low,
	output logic                   divide_by_zero
);

	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] dsr_q;
	logic [WORD_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              dbz_q;
	logic [WORD_W-1:0] quo_out_q;
	logic              dbz_out_q;
	logic [WORD_W:0]   diff_w;
	logic              fits_w;
	logic              below_w;

	// One shared subtractor: its borrow gives divisor <= remainder.
	assign diff_w  = {1'b0, rem_q} - {1'b0, dsr_q};
	assign fits_w  = ~diff_w[WORD_W];
	assign below_w = fits_w && (diff_w[WORD_W-1:0] != '0);

	assign sts.dbz       = dbz_q;
	assign sts.can_shift = ~dsr_q[WORD_W-1] && below_w;
	assign sts.cnt_zero  = (cnt_q == '0);

	// Working registers: remainder, shifted divisor and quotient.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= {dividend_high, dividend_low};
			dsr_q <= {divisor_high, divisor_low};
			quo_q <= '0;
		end else if (cmd.shift_up) begin
			dsr_q <= {dsr_q[WORD_W-2:0], 1'b0};
		end else if (cmd.step) begin
			if (fits_w) begin
				rem_q <= diff_w[WORD_W-1:0];
			end
			dsr_q <= {1'b0, dsr_q[WORD_W-1:1]};
			quo_q <= {quo_q[WORD_W-2:0], fits_w};
		end
	end

	// Shift count and zero-divisor flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			dbz_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q <= '0;
			dbz_q <= ({divisor_high, divisor_low} == '0);
		end else if (cmd.shift_up) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Output register holds the result beat while it waits.
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			quo_out_q <= quo_q;
			dbz_out_q <= dbz_q;
		end
	end

	assign quotient_high  = quo_out_q[WORD_W-1:HALF_W];
	assign quotient_low   = quo_out_q[HALF_W-1:0];
	assign divide_by_zero = dbz_out_q;

`ifndef NO_ASSERTIONS
	// Alignment never pushes a set bit out of the divisor.
	a_shift_keeps_msb: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_up |-> !dsr_q[WORD_W-1])
		else $error("divisor shifted past its top bit");

	// A zero divisor publishes a zero quotient.
	a_dbz_zero_quo: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.publish && dbz_q) |-> (quo_q == '0))
		else $error("nonzero quotient on divide by zero");

	// Each division step works with a nonzero divisor.
	a_step_dsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (dsr_q != '0))
		else $error("division step with zero divisor");
`endif

endmodule

`default_nettype wire

FILE: src/u128div_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module u128div_ctrl
	import u128div_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  wire logic         rsp_ready,
	input  wire u128div_sts_t sts,
	output u128div_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_ALIGN  = 2'd1;
	localparam logic [1:0] ST_DIVIDE = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Next state and datapath commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				if (sts.dbz) begin
					state_d = ST_DONE;
				end else if (sts.can_shift) begin
					cmd.shift_up = 1'b1;
				end else begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.step = 1'b1;
				if (sts.cnt_zero) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and output beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// An accepted beat starts alignment in the next cycle.
	a_accept_aligns: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == ST_ALIGN))
		else $error("accepted beat did not start alignment");

	// A new result beat appears only after the finishing state.
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result beat raised outside the finishing state");

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!rsp_valid_q || rsp_ready))
		else $error("result beat overwritten while waiting");
`endif

endmodule

`default_nettype wire
